[sv/sfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, widths, codes and command/status bundles.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int FRAME_W    = 10;
  localparam int MAX_FRAMES = 1024;
  localparam int TOTAL_W    = 11;
  localparam int COLS_W     = 11;
  localparam int PERIOD_W   = 24;
  localparam int ACC_W      = 25;
  localparam int DELTA_W    = 16;
  localparam int PIX_W      = 12;
  localparam int VIEW_W     = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = FRAME_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100000);

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_PLAY    = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_PAUSE   = 3'd3,
    REQ_RESET   = 3'd4,
    REQ_SET_DIR = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_PERIOD = 3'd0,
    CFG_FRAME_TOTAL  = 3'd1,
    CFG_COLUMN_COUNT = 3'd2,
    CFG_STEP_X       = 3'd3,
    CFG_STEP_Y       = 3'd4,
    CFG_ORIGIN_X     = 3'd5,
    CFG_ORIGIN_Y     = 3'd6,
    CFG_LOOP_ENABLE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [DELTA_W-1:0] delta_time;
    logic               reverse_flag;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [VIEW_W-1:0]  view_x;
    logic [VIEW_W-1:0]  view_y;
    logic               playing;
    logic               backward;
    logic               ended;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

[sv/sfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer controller
// Sequences event update, index division, position multiply and output load.
// ----------------------------------------------------------------------------
module sfs_ctrl
  import sfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_valid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_HOLD;
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/sfs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer datapath
// Config registers, playback state, serial index divider and position unit.
// ----------------------------------------------------------------------------
module sfs_datapath
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output out_item_t             out_data
);

  logic [PERIOD_W-1:0] period_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [COLS_W-1:0]   cols_r;
  logic [PIX_W-1:0]    step_x_r, step_y_r, origin_x_r, origin_y_r;
  logic                loop_r;

  logic               run_r, run_nxt;
  logic               dir_r, dir_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               ended_r, ended_nxt;

  logic [FRAME_W-1:0] dvd_r, dvd_nxt;
  logic [COLS_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [VIEW_W-1:0]  res_x_r, res_y_r;
  out_item_t          out_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RST;
      total_r    <= TOTAL_W'(1);
      cols_r     <= COLS_W'(1);
      step_x_r   <= '0;
      step_y_r   <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      loop_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_PERIOD: period_r   <= cfg_data[PERIOD_W-1:0];
        CFG_FRAME_TOTAL:  total_r    <= cfg_data[TOTAL_W-1:0];
        CFG_COLUMN_COUNT: cols_r     <= cfg_data[COLS_W-1:0];
        CFG_STEP_X:       step_x_r   <= cfg_data[PIX_W-1:0];
        CFG_STEP_Y:       step_y_r   <= cfg_data[PIX_W-1:0];
        CFG_ORIGIN_X:     origin_x_r <= cfg_data[PIX_W-1:0];
        CFG_ORIGIN_Y:     origin_y_r <= cfg_data[PIX_W-1:0];
        CFG_LOOP_ENABLE:  loop_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [TOTAL_W-1:0] total_eff;
  logic [FRAME_W-1:0] last_frame;
  logic [COLS_W-1:0]  cols_eff;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [TOTAL_W-1:0] fwd_frame;

  always_comb begin
    if (total_r == '0)                            total_eff = TOTAL_W'(1);
    else if (total_r > TOTAL_W'(MAX_FRAMES))      total_eff = TOTAL_W'(MAX_FRAMES);
    else                                          total_eff = total_r;
    last_frame = FRAME_W'(total_eff - TOTAL_W'(1));
    cols_eff   = (cols_r == '0) ? COLS_W'(1) : cols_r;
    acc_sum    = {1'b0, acc_r} + (ACC_W+1)'(in_data.delta_time);
    acc_sat    = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    fwd_frame  = {1'b0, frame_r} + TOTAL_W'(1);
  end

  // event update
  always_comb begin
    run_nxt   = run_r;
    dir_nxt   = dir_r;
    acc_nxt   = acc_r;
    frame_nxt = frame_r;
    ended_nxt = 1'b0;
    case (in_data.req_type)
      REQ_TICK: begin
        if (run_r) begin
          acc_nxt = acc_sat;
          if (acc_sat >= ACC_W'(period_r)) begin
            acc_nxt = '0;
            if (!dir_r) begin
              if (fwd_frame >= total_eff) begin
                if (loop_r) begin
                  frame_nxt = '0;
                end else begin
                  frame_nxt = last_frame;
                  run_nxt   = 1'b0;
                  ended_nxt = 1'b1;
                end
              end else begin
                frame_nxt = fwd_frame[FRAME_W-1:0];
              end
            end else if (frame_r == '0) begin
              if (loop_r) begin
                frame_nxt = last_frame;
              end else begin
                run_nxt   = 1'b0;
                ended_nxt = 1'b1;
              end
            end else begin
              frame_nxt = frame_r - FRAME_W'(1);
            end
          end
        end
      end
      REQ_PLAY: begin
        run_nxt   = 1'b1;
        frame_nxt = dir_r ? last_frame : '0;
        acc_nxt   = '0;
      end
      REQ_STOP: begin
        run_nxt = 1'b0;
        acc_nxt = '0;
      end
      REQ_PAUSE: run_nxt = 1'b0;
      REQ_RESET: begin
        frame_nxt = dir_r ? last_frame : '0;
        acc_nxt   = '0;
      end
      REQ_SET_DIR: begin
        if (dir_r != in_data.reverse_flag) begin
          dir_nxt   = in_data.reverse_flag;
          frame_nxt = in_data.reverse_flag ? last_frame : '0;
          acc_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      dir_r   <= 1'b0;
      acc_r   <= '0;
      frame_r <= '0;
      ended_r <= 1'b0;
    end else if (cmd.accept) begin
      run_r   <= run_nxt;
      dir_r   <= dir_nxt;
      acc_r   <= acc_nxt;
      frame_r <= frame_nxt;
      ended_r <= ended_nxt;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [COLS_W:0] rem_sh;
  logic            fits;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[FRAME_W-1]};
    fits    = rem_sh >= {1'b0, cols_eff};
    rem_nxt = fits ? COLS_W'(rem_sh - {1'b0, cols_eff}) : rem_sh[COLS_W-1:0];
    dvd_nxt = {dvd_r[FRAME_W-2:0], fits};
  end

  assign status.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dvd_r <= frame_nxt;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // cell position: quotient in dvd_r, remainder in rem_r
  logic [VIEW_W-1:0] prod_x, prod_y;

  assign prod_x = VIEW_W'(rem_r[FRAME_W-1:0]) * VIEW_W'(step_x_r);
  assign prod_y = VIEW_W'(dvd_r) * VIEW_W'(step_y_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      res_x_r <= {{(VIEW_W-PIX_W){1'b0}}, origin_x_r} + prod_x;
      res_y_r <= {{(VIEW_W-PIX_W){1'b0}}, origin_y_r} + prod_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.frame_index <= frame_r;
      out_r.view_x      <= res_x_r;
      out_r.view_y      <= res_y_r;
      out_r.playing     <= run_r;
      out_r.backward    <= dir_r;
      out_r.ended       <= ended_r;
    end
  end

  assign out_data = out_r;

endmodule

[sv/sprite_frame_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Sprite-sheet animation state with frame index to cell position mapping.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one event per beat (tick, play, stop, pause, reset, set direction),
//           valid/ready handshake.
//   out_* : one result beat per event: frame index, cell x/y, status flags.
//   cfg_* : register writes, taken on any edge with cfg_wr_en high; write only
//           while no event is in flight.
// Sequence: the index split runs in a restoring divider (one quotient bit
//   per cycle), then a multiply-add and a load into the output register,
//   which waits until the output register is free.
// Flow: in_ready is high only between events. A waiting result sits in
//   the output register, and the next event is accepted meanwhile.
// Stall: if out_ready stays low the finished result waits in the datapath,
//   in_ready stays low until the output register can take it.
// Reset: rst_n (synchronous) restores register defaults, stops playback,
//   selects forward direction, clears frame and elapsed time.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // busy after accepting a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // a new result is only loaded at the end of an event, never while idle
  a_load_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !in_ready)
    else $error("output loaded while idle");

  // an ended result always reports playback stopped
  a_ended_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ended) |-> !out_data.playing)
    else $error("ended result still playing");

  // divider steps never overlap with accepting a new event
  a_no_step_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.div_step || cmd.mul_en || cmd.load_out))
    else $error("datapath command during accept");

endmodule
